// ===== design/sm83_alu_pkg.sv =====
package sm83_alu_pkg;

	localparam int unsigned OP_W        = 6;
	localparam int unsigned IN_TDATA_W  = 48;
	localparam int unsigned OUT_TDATA_W = 32;

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 6'd0,
		OP_ADC   = 6'd1,
		OP_SUB   = 6'd2,
		OP_SBC   = 6'd3,
		OP_AND   = 6'd4,
		OP_XOR   = 6'd5,
		OP_OR    = 6'd6,
		OP_CP    = 6'd7,
		OP_INC8  = 6'd8,
		OP_DEC8  = 6'd9,
		OP_DAA   = 6'd10,
		OP_CPL   = 6'd11,
		OP_WRC   = 6'd12,
		OP_RLCA  = 6'd13,
		OP_RRCA  = 6'd14,
		OP_RLA   = 6'd15,
		OP_RRA   = 6'd16,
		OP_RLC   = 6'd17,
		OP_RRC   = 6'd18,
		OP_RL    = 6'd19,
		OP_RR    = 6'd20,
		OP_SLA   = 6'd21,
		OP_SRA   = 6'd22,
		OP_SWAP  = 6'd23,
		OP_SRL   = 6'd24,
		OP_BIT   = 6'd25,
		OP_SET   = 6'd26,
		OP_RES   = 6'd27,
		OP_ADD16 = 6'd28,
		OP_SPOFS = 6'd29,
		OP_INC16 = 6'd30,
		OP_DEC16 = 6'd31,
		OP_LDA   = 6'd32
	} op_t;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

	typedef struct packed {
		logic [7:0]  rb;
		logic [15:0] rw;
		flags_t      fl;
		logic        wa;
	} alu_res_t;

	typedef struct packed {
		logic [5:0]  op;
		logic [7:0]  operand;
		logic [2:0]  bit_index;
		logic [15:0] wide_left;
		logic [15:0] wide_right;
		logic        new_carry;
	} alu_req_t;

endpackage

// ===== design/sm83_alu_core.sv =====
module sm83_alu_core
	import sm83_alu_pkg::*;
(
	input  alu_req_t   req,
	input  logic [7:0] acc,
	input  flags_t     flags,
	output alu_res_t   res
);

	op_t         op;
	logic [7:0]  v;
	logic [8:0]  sum9;
	logic [4:0]  nib5;
	logic [16:0] sum17;
	logic [12:0] sum13;
	logic [7:0]  corr;
	logic [7:0]  src;
	logic [7:0]  mask;
	logic [7:0]  shifted;
	logic        sh_c;
	logic        left;
	logic        ins;
	logic        t;
	logic        cin;

	assign op = op_t'(req.op);
	assign v  = req.operand;

	always_comb begin
		cin   = flags.c;
		sum9  = '0;
		nib5  = '0;
		sum17 = '0;
		sum13 = '0;
		corr  = '0;
		t     = 1'b0;
		mask  = 8'd1 << req.bit_index;

		// shared rotate and shift unit
		src  = (op inside {OP_RLCA, OP_RRCA, OP_RLA, OP_RRA}) ? acc : v;
		left = op inside {OP_RLCA, OP_RLA, OP_RLC, OP_RL, OP_SLA};
		case (op)
			OP_RLCA, OP_RLC:                ins = src[7];
			OP_RRCA, OP_RRC:                ins = src[0];
			OP_RLA, OP_RRA, OP_RL, OP_RR:   ins = cin;
			OP_SRA:                         ins = src[7];
			default:                        ins = 1'b0;
		endcase
		shifted = left ? {src[6:0], ins} : {ins, src[7:1]};
		sh_c    = left ? src[7] : src[0];

		res.rb = acc;
		res.rw = '0;
		res.fl = flags;
		res.wa = 1'b0;

		case (op)
			OP_ADD, OP_ADC: begin
				t         = (op == OP_ADC) & cin;
				sum9      = {1'b0, acc} + {1'b0, v} + {8'd0, t};
				nib5      = {1'b0, acc[3:0]} + {1'b0, v[3:0]} + {4'd0, t};
				res.rb    = sum9[7:0];
				res.fl    = '{z: sum9[7:0] == 8'd0, n: 1'b0, h: nib5[4], c: sum9[8]};
				res.wa    = 1'b1;
			end
			OP_SUB, OP_SBC, OP_CP: begin
				t         = (op == OP_SBC) & cin;
				sum9      = {1'b0, acc} - {1'b0, v} - {8'd0, t};
				nib5      = {1'b0, acc[3:0]} - {1'b0, v[3:0]} - {4'd0, t};
				res.fl    = '{z: sum9[7:0] == 8'd0, n: 1'b1, h: nib5[4], c: sum9[8]};
				if (op != OP_CP) begin
					res.rb = sum9[7:0];
					res.wa = 1'b1;
				end
			end
			OP_AND, OP_XOR, OP_OR: begin
				res.rb = (op == OP_AND) ? (acc & v) : (op == OP_XOR) ? (acc ^ v) : (acc | v);
				res.fl = '{z: res.rb == 8'd0, n: 1'b0, h: op == OP_AND, c: 1'b0};
				res.wa = 1'b1;
			end
			OP_INC8: begin
				res.rb   = v + 8'd1;
				res.fl.z = res.rb == 8'd0;
				res.fl.n = 1'b0;
				res.fl.h = v[3:0] == 4'hF;
			end
			OP_DEC8: begin
				res.rb   = v - 8'd1;
				res.fl.z = res.rb == 8'd0;
				res.fl.n = 1'b1;
				res.fl.h = v[3:0] == 4'h0;
			end
			OP_DAA: begin
				res.fl.c = 1'b0;
				if (!flags.n) begin
					if (flags.c || acc > 8'h99) begin
						res.fl.c = 1'b1;
						corr     = corr | 8'h60;
					end
					if (flags.h || acc[3:0] > 4'h9)
						corr = corr | 8'h06;
				end else if (flags.c) begin
					res.fl.c = 1'b1;
					corr     = flags.h ? 8'h9A : 8'hA0;
				end else if (flags.h) begin
					corr = 8'hFA;
				end
				res.rb   = acc + corr;
				res.fl.z = res.rb == 8'd0;
				res.fl.h = 1'b0;
				res.wa   = 1'b1;
			end
			OP_CPL: begin
				res.rb   = ~acc;
				res.fl.n = 1'b1;
				res.fl.h = 1'b1;
				res.wa   = 1'b1;
			end
			OP_WRC: begin
				res.fl.n = 1'b0;
				res.fl.h = 1'b0;
				res.fl.c = req.new_carry;
			end
			OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
				res.rb = shifted;
				res.fl = '{z: 1'b0, n: 1'b0, h: 1'b0, c: sh_c};
				res.wa = 1'b1;
			end
			OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SRL: begin
				res.rb = shifted;
				res.fl = '{z: shifted == 8'd0, n: 1'b0, h: 1'b0, c: sh_c};
			end
			OP_SWAP: begin
				res.rb = {v[3:0], v[7:4]};
				res.fl = '{z: v == 8'd0, n: 1'b0, h: 1'b0, c: 1'b0};
			end
			OP_BIT: begin
				res.rb   = v;
				res.fl.z = (v & mask) == 8'd0;
				res.fl.n = 1'b0;
				res.fl.h = 1'b1;
			end
			OP_SET: res.rb = v | mask;
			OP_RES: res.rb = v & ~mask;
			OP_ADD16: begin
				sum17    = {1'b0, req.wide_left} + {1'b0, req.wide_right};
				sum13    = {1'b0, req.wide_left[11:0]} + {1'b0, req.wide_right[11:0]};
				res.rw   = sum17[15:0];
				res.fl.n = 1'b0;
				res.fl.h = sum13[12];
				res.fl.c = sum17[16];
			end
			OP_SPOFS: begin
				// H and C come from the unsigned low byte of SP plus the raw offset
				res.rw = req.wide_left + {{8{v[7]}}, v};
				nib5   = {1'b0, req.wide_left[3:0]} + {1'b0, v[3:0]};
				sum9   = {1'b0, req.wide_left[7:0]} + {1'b0, v};
				res.fl = '{z: 1'b0, n: 1'b0, h: nib5[4], c: sum9[8]};
			end
			OP_INC16: res.rw = req.wide_left + 16'd1;
			OP_DEC16: res.rw = req.wide_left - 16'd1;
			OP_LDA: begin
				res.rb = v;
				res.wa = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// ===== design/sm83_alu_with_flags.sv =====
// SM83 accumulator ALU with Z/N/H/C flags.
// Input channel s_axis_*: one operation per transaction; tuser carries the
// operation code, tdata the operands. Output channel m_axis_*: one result
// transaction per input, in order, carrying the byte result, the 16-bit
// result and the four flags after the operation.
// The accumulator and flag register live inside the block and are updated
// as each operation leaves the input register for the result register, so
// the next operation sees them without a gap.
// Each operation passes through the input register, then the result register.
// Throughput: one operation per cycle while the receiver does not stall; the
// single ALU pass between the two registers sets it.
// Reset clears the accumulator, the flags and both valid bits.
// When the receiver stalls, the result register holds, the input register
// fills behind it, and s_axis_tready drops only when both are occupied.
module sm83_alu_with_flags
	import sm83_alu_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [7:0] operand, [10:8] bit_index, [26:11] wide_left, [42:27] wide_right,
	// [43] new_carry, [47:44] zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// [5:0] req_type
	input  logic [OP_W-1:0]        s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [7:0] result_byte, [23:8] result_word, [24] zero_out, [25] subtract_out,
	// [26] half_carry_out, [27] carry_out, [31:28] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic       valid_s1;
	alu_req_t   req_s1;
	logic       valid_s2;
	alu_res_t   res_s2;
	alu_res_t   res;
	logic [7:0] acc_q;
	flags_t     flags_q;
	logic       adv;

	assign adv           = valid_s1 & (~valid_s2 | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_s1.op         <= s_axis_tuser;
			req_s1.operand    <= s_axis_tdata[7:0];
			req_s1.bit_index  <= s_axis_tdata[10:8];
			req_s1.wide_left  <= s_axis_tdata[26:11];
			req_s1.wide_right <= s_axis_tdata[42:27];
			req_s1.new_carry  <= s_axis_tdata[43];
		end
	end

	sm83_alu_core u_core (
		.req   (req_s1),
		.acc   (acc_q),
		.flags (flags_q),
		.res   (res)
	);

	// commit architectural state as the operation moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			flags_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv) begin
				flags_q  <= res.fl;
				valid_s2 <= 1'b1;
				if (res.wa)
					acc_q <= res.rb;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'd0, res_s2.fl.c, res_s2.fl.h, res_s2.fl.n, res_s2.fl.z,
		res_s2.rw, res_s2.rb};

`ifndef SYNTHESIS
	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(acc_q))
		else $error("accumulator changed without an operation retiring");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while result register empty");

	a_flags_match: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_axis_tvalid && flags_q == {m_axis_tdata[24], m_axis_tdata[25],
			m_axis_tdata[26], m_axis_tdata[27]})
		else $error("flag register disagrees with presented flags");
`endif

endmodule
